// ===== hdl/npc_pkg.sv =====
// Shared constants, types and helpers for the nearest point classifier.
// No dependencies.
package npc_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int COORD_W = 16;
  localparam int DIST_W = 34;
  localparam int SLOT_W = 6;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_DEL = 2'd1;
  localparam logic [1:0] MODE_QRY = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] PROX_AT = 2'd0;
  localparam logic [1:0] PROX_NEAR = 2'd1;
  localparam logic [1:0] PROX_SIDE = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Squared difference of one axis; at most 2^32.
  function automatic logic [32:0] sq_axis(input logic signed [COORD_W-1:0] a,
                                          input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0] u;
    begin
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      u = d[COORD_W] ? 17'(-d) : 17'(d);
      sq_axis = 33'(u) * 33'(u);
    end
  endfunction

endpackage

// ===== hdl/npc_cell.sv =====
// One cell of the point ring: holds one point and its valid bit and hands
// both to its neighbour on every ring step. Depends on npc_pkg.
module npc_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic wr_en,
  input  logic clr_en,
  input  npc_pkg::point_t wr_point,
  input  npc_pkg::point_t point_in,
  input  logic valid_in,
  output npc_pkg::point_t point_out,
  output logic valid_out
);
  npc_pkg::point_t point;
  logic valid;

  always_ff @(posedge clk) begin
    if (shift) begin
      point <= point_in;
    end else if (wr_en) begin
      point <= wr_point;
    end
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end else if (wr_en) begin
      valid <= 1'b1;
    end else if (clr_en) begin
      valid <= 1'b0;
    end
  end

  assign point_out = point;
  assign valid_out = valid;
endmodule

// ===== hdl/nearest_point_proximity_classifier.sv =====
// Top level of the nearest point classifier: a rotating ring of point cells,
// a scan sequencer, one distance pipeline and the class logic. Depends on npc_pkg and npc_cell.
//
// channel   direction  handshake        payload
// in        in         in_valid/stall   mode slot pos_x pos_y pos_z
// out       out        out_valid/stall  status result_slot proximity dist_sq
// cfg       in         cfg_we           cfg_data (keywords_enable)
//
// The points sit in a ring of SLOTS cells; while scanning it steps one cell a
// cycle and cell 0 passes slots 0..SLOTS-1 in order through a 3-stage distance pipe.
// A query: one turn of the ring, then the drain and done states before the result.
// Add and delete: SLOTS-1 turns for the pair rescan, then drain and done as for a query.
// Full table, bad delete and unused mode answer at the accepting edge.
// Reset clears all valid bits and the pair minimum; no clearing pass.
// A stalled result holds in the output register; no new request is taken
// until it has gone, so the next accept can come in the cycle after the result leaves.
module nearest_point_proximity_classifier #(
  parameter int SLOTS = npc_pkg::SLOTS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] mode,
  input  logic [5:0] slot,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [5:0] result_slot,
  output logic [1:0] proximity,
  output logic [33:0] dist_sq
);
  localparam int IW = $clog2(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t state;
  logic keywords_enable;
  logic [1:0] op;
  npc_pkg::point_t probe;
  logic probe_valid;
  logic [IW-1:0] step;
  logic [IW-1:0] pass;
  logic best_found;
  logic [33:0] best;
  logic [IW-1:0] best_idx;
  logic has_pair;
  logic [33:0] min_pair;

  npc_pkg::point_t pt [SLOTS];
  logic vld [SLOTS];

  logic shift;
  logic accept;
  logic [SLOTS-1:0] valid_vec;
  logic [SLOTS-1:0] wr_sel;
  logic [SLOTS-1:0] clr_sel;
  logic [IW-1:0] free_idx;
  logic free_found;
  logic [IW-1:0] slot_idx;
  logic del_ok;
  logic head_use;
  npc_pkg::point_t in_point;

  logic a_use;
  logic [IW-1:0] a_idx;
  logic [32:0] a_sqx, a_sqy, a_sqz;
  logic b_use;
  logic [IW-1:0] b_idx;
  logic [33:0] b_d;

  logic [40:0] q121;
  logic [40:0] m100;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign shift = (state == S_SCAN);
  assign in_point = '{x: pos_x, y: pos_y, z: pos_z};
  assign slot_idx = IW'(slot);
  assign del_ok = (int'(slot) < SLOTS) && valid_vec[slot_idx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      valid_vec[i] = vld[i];
      if (!vld[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // The ring is at home while idle, so cell g holds slot g.
  always_comb begin
    wr_sel = '0;
    clr_sel = '0;
    if (accept && mode == npc_pkg::MODE_ADD && free_found) begin
      wr_sel[free_idx] = 1'b1;
    end
    if (accept && mode == npc_pkg::MODE_DEL && del_ok) begin
      clr_sel[slot_idx] = 1'b1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      localparam int NX = (g == SLOTS - 1) ? 0 : g + 1;
      npc_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift),
        .wr_en(wr_sel[g]), .clr_en(clr_sel[g]), .wr_point(in_point),
        .point_in(pt[NX]), .valid_in(vld[NX]),
        .point_out(pt[g]), .valid_out(vld[g])
      );
    end
  endgenerate

  // In a rescan pass, only pair with later slots of a valid probe.
  assign head_use = vld[0] &&
                    ((op == npc_pkg::MODE_QRY) || (probe_valid && (step > pass)));

  // Distance pipe: squares, then sum, then the running minimum.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_use <= 1'b0;
      b_use <= 1'b0;
    end else begin
      a_use <= shift && head_use;
      b_use <= a_use;
    end
    a_idx <= step;
    a_sqx <= npc_pkg::sq_axis(pt[0].x, probe.x);
    a_sqy <= npc_pkg::sq_axis(pt[0].y, probe.y);
    a_sqz <= npc_pkg::sq_axis(pt[0].z, probe.z);
    b_idx <= a_idx;
    b_d <= 34'(a_sqx) + 34'(a_sqy) + 34'(a_sqz);
  end

  // 121*d and 100*m by shifts and adds; both fit in 41 bits
  assign q121 = (41'(best) << 7) - (41'(best) << 3) + 41'(best);
  assign m100 = (41'(min_pair) << 6) + (41'(min_pair) << 5) + (41'(min_pair) << 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      keywords_enable <= 1'b0;
      has_pair <= 1'b0;
      min_pair <= '0;
      step <= '0;
      pass <= '0;
    end else begin
      if (cfg_we) begin
        keywords_enable <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // strict less keeps the lowest slot on ties
      if (b_use && (!best_found || b_d < best)) begin
        best <= b_d;
        best_idx <= b_idx;
        best_found <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= mode;
            probe <= in_point;
            probe_valid <= 1'b0;
            status <= npc_pkg::ST_OK;
            result_slot <= '0;
            proximity <= npc_pkg::PROX_AT;
            dist_sq <= '0;
            step <= '0;
            pass <= '0;
            best_found <= 1'b0;
            best <= '0;
            priority if (mode == npc_pkg::MODE_ADD) begin
              if (!free_found) begin
                status <= npc_pkg::ST_FULL;
                out_valid <= 1'b1;
              end else begin
                result_slot <= 6'(free_idx);
                state <= S_SCAN;
              end
            end else if (mode == npc_pkg::MODE_DEL) begin
              result_slot <= slot;
              if (del_ok) begin
                state <= S_SCAN;
              end else begin
                status <= npc_pkg::ST_EMPTY;
                out_valid <= 1'b1;
              end
            end else if (mode == npc_pkg::MODE_QRY) begin
              state <= S_SCAN;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // take slot 'pass' as the probe when it passes cell 0
          if (op != npc_pkg::MODE_QRY && step == pass) begin
            probe <= pt[0];
            probe_valid <= vld[0];
          end
          if (step == IW'(SLOTS - 1)) begin
            step <= '0;
            if (op == npc_pkg::MODE_QRY || pass == IW'(SLOTS - 2)) begin
              pass <= '0;
              state <= S_DRAIN;
            end else begin
              pass <= pass + IW'(1);
            end
          end else begin
            step <= step + IW'(1);
          end
        end
        S_DRAIN: begin
          if (step == IW'(1)) begin
            step <= '0;
            state <= S_DONE;
          end else begin
            step <= step + IW'(1);
          end
        end
        S_DONE: begin
          if (op == npc_pkg::MODE_QRY) begin
            if (!best_found) begin
              status <= npc_pkg::ST_EMPTY;
            end else begin
              result_slot <= 6'(best_idx);
              dist_sq <= best;
              if (!keywords_enable) begin
                proximity <= npc_pkg::PROX_AT;
              end else if (!has_pair) begin
                proximity <= npc_pkg::PROX_SIDE;
              end else if ({best, 2'b00} < {2'b00, min_pair}) begin
                proximity <= npc_pkg::PROX_AT;
              end else if (q121 < m100) begin
                proximity <= npc_pkg::PROX_NEAR;
              end else begin
                proximity <= npc_pkg::PROX_SIDE;
              end
            end
          end else begin
            has_pair <= best_found;
            min_pair <= best_found ? best : '0;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (step == '0 && pass == '0))
    else $error("ring not at home while idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
      $stable(result_slot) && $stable(proximity) && $stable(dist_sq)))
    else $error("result dropped or changed under stall");
  a_nostart: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while result pending");
endmodule
